/* sv/sltseq_pkg.sv */
// Package with shared constants, codes and payload types of the section load transfer sequencer.
package sltseq_pkg;

    localparam int NUM_SECTIONS = 18;
    localparam int CHUNK_BYTES  = 131072;
    localparam int HEADER_BYTES = 256;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int ENTRY_W   = 5;
    localparam int BYTES_W   = 18;
    localparam int PHASE_W   = $clog2(NUM_SECTIONS + 2);
    localparam int TAB_IDX_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int ALIGN     = 32;

    localparam int APB_ADDR_W = 3;
    localparam logic APB_SEL_IMAGE_OFFSET = 1'b0;
    localparam logic APB_SEL_HEADER_BUF   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESTART     = 2'd0,
        CMD_WRITE_ENTRY = 2'd1,
        CMD_REQUEST     = 2'd2,
        CMD_UNUSED      = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ENTRY_W-1:0] entry_index;
        logic [DATA_W-1:0]  entry_file_offset;
        logic [DATA_W-1:0]  entry_load_address;
        logic [DATA_W-1:0]  entry_byte_size;
    } req_t;

    typedef struct packed {
        logic               transfer_valid;
        logic               header_transfer;
        logic [DATA_W-1:0]  destination_address;
        logic [BYTES_W-1:0] transfer_bytes;
        logic [DATA_W-1:0]  source_disc_offset;
    } rsp_t;

endpackage

/* sv/section_load_transfer_sequencer.sv */
// Top level of the section load transfer sequencer: table memory, shared adder and sequencer.
// Steps: a restart, entry write or unused command completes on acceptance; a header
// request goes to emit; a chunk passes read, round, remain, dst, src base, src sum, advance
// and emit, with read, round and remain again per empty or finished section skipped.
// Throughput: one item at a time; the single 32-bit adder is stepped by the sequencer.
// Reset: rst_n clears phase, progress, the valid bits of the section table and the
// configuration registers; table offsets, addresses and sizes are not cleared.
module section_load_transfer_sequencer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  sltseq_pkg::req_t                      req_data,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output sltseq_pkg::rsp_t                      rsp_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sltseq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sltseq_pkg::DATA_W-1:0]         pwdata,
    output logic [sltseq_pkg::DATA_W-1:0]         prdata,
    output logic                                  pready
);
    import sltseq_pkg::*;

    // The sequencer walks through these steps for each request. Every arithmetic
    // step uses the one shared adder below.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ROUND,
        ST_REMAIN,
        ST_DST,
        ST_SRC_BASE,
        ST_SRC_SUM,
        ST_ADVANCE,
        ST_EMIT
    } state_t;

    localparam logic [DATA_W-1:0]  ALIGN_M1    = DATA_W'(ALIGN - 1);
    localparam logic [DATA_W-1:0]  ALIGN_MASK  = ~ALIGN_M1;
    localparam logic [DATA_W-1:0]  CHUNK_LIMIT = DATA_W'(CHUNK_BYTES);
    localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(NUM_SECTIONS);
    localparam logic [PHASE_W-1:0] PHASE_DONE  = PHASE_W'(NUM_SECTIONS + 1);

    // ------------------------------------------------------------------
    // Configuration registers. The APB port is always ready and a write
    // lands on the access cycle.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] image_offset_reg;
    logic [DATA_W-1:0] header_buf_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_offset_reg <= '0;
            header_buf_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                APB_SEL_IMAGE_OFFSET: image_offset_reg <= pwdata;
                APB_SEL_HEADER_BUF:   header_buf_reg   <= pwdata;
                default:              image_offset_reg <= image_offset_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            APB_SEL_IMAGE_OFFSET: prdata = image_offset_reg;
            APB_SEL_HEADER_BUF:   prdata = header_buf_reg;
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state and registered outputs.
    // ------------------------------------------------------------------
    state_t             state_reg,     state_next;
    logic [PHASE_W-1:0] phase_reg,     phase_next;
    logic [DATA_W-1:0]  progress_reg,  progress_next;
    logic [DATA_W-1:0]  size_reg,      size_next;
    logic [BYTES_W-1:0] want_reg,      want_next;
    logic [DATA_W-1:0]  dst_reg,       dst_next;
    logic [DATA_W-1:0]  src_reg,       src_next;
    logic               res_valid_reg, res_valid_next;
    logic               res_header_reg, res_header_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_data_reg,  rsp_data_next;

    // Section table. Offsets, addresses and sizes sit in a small memory with a
    // registered read port; a valid bit per slot makes unwritten sizes read as zero.
    logic [DATA_W-1:0]       table_offsets   [NUM_SECTIONS];
    logic [DATA_W-1:0]       table_addresses [NUM_SECTIONS];
    logic [DATA_W-1:0]       table_sizes     [NUM_SECTIONS];
    logic [NUM_SECTIONS-1:0] present_reg;
    logic [DATA_W-1:0]       rd_off_reg;
    logic [DATA_W-1:0]       rd_addr_reg;
    logic [DATA_W-1:0]       rd_size_reg;
    logic                    rd_present_reg;

    logic                 req_accept;
    logic                 entry_write;
    logic [TAB_IDX_W-1:0] wr_idx;
    logic [TAB_IDX_W-1:0] rd_idx;
    logic [PHASE_W-1:0]   phase_prev;

    assign req_stall   = (state_reg != ST_IDLE);
    assign req_accept  = req_valid && !req_stall;
    assign entry_write = req_accept && (req_data.command == CMD_WRITE_ENTRY)
                         && (int'(req_data.entry_index) < NUM_SECTIONS);
    assign wr_idx      = TAB_IDX_W'(req_data.entry_index);
    assign phase_prev  = phase_reg - PHASE_W'(1);
    assign rd_idx      = TAB_IDX_W'(phase_prev);

    always_ff @(posedge clk)
    begin
        if (entry_write)
        begin
            table_offsets[wr_idx]   <= req_data.entry_file_offset;
            table_addresses[wr_idx] <= req_data.entry_load_address;
            table_sizes[wr_idx]     <= req_data.entry_byte_size;
        end
        if (state_reg == ST_READ)
        begin
            rd_off_reg  <= table_offsets[rd_idx];
            rd_addr_reg <= table_addresses[rd_idx];
            rd_size_reg <= table_sizes[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            rd_present_reg <= 1'b0;
        end
        else
        begin
            if (entry_write)
            begin
                present_reg[wr_idx] <= 1'b1;
            end
            if (state_reg == ST_READ)
            begin
                rd_present_reg <= present_reg[rd_idx];
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared adder. Subtraction feeds the inverted operand with a carry in;
    // the carry out then tells whether a >= b.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] alu_a;
    logic [DATA_W-1:0] alu_b;
    logic              alu_sub;
    logic [DATA_W:0]   alu_sum;
    logic [DATA_W-1:0] alu_res;
    logic              alu_carry;

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + {{DATA_W{1'b0}}, alu_sub};
    assign alu_res   = alu_sum[DATA_W-1:0];
    assign alu_carry = alu_sum[DATA_W];

    always_comb
    begin
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_ROUND:
            begin
                alu_a = rd_present_reg ? rd_size_reg : '0;
                alu_b = ALIGN_M1;
            end
            ST_REMAIN:
            begin
                alu_a   = size_reg;
                alu_b   = progress_reg;
                alu_sub = 1'b1;
            end
            ST_DST:
            begin
                alu_a = rd_addr_reg;
                alu_b = progress_reg;
            end
            ST_SRC_BASE:
            begin
                alu_a = image_offset_reg;
                alu_b = rd_off_reg;
            end
            ST_SRC_SUM:
            begin
                alu_a = src_reg;
                alu_b = progress_reg;
            end
            ST_ADVANCE:
            begin
                alu_a = progress_reg;
                alu_b = {{(DATA_W-BYTES_W){1'b0}}, want_reg};
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next-state logic of the sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        progress_next   = progress_reg;
        size_next       = size_reg;
        want_next       = want_reg;
        dst_next        = dst_reg;
        src_next        = src_reg;
        res_valid_next  = res_valid_reg;
        res_header_next = res_header_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_data_next   = rsp_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    unique case (cmd_t'(req_data.command))
                        CMD_RESTART:
                        begin
                            phase_next    = '0;
                            progress_next = '0;
                        end
                        CMD_REQUEST:
                        begin
                            if (phase_reg == '0)
                            begin
                                // First request after a restart reads the image header.
                                phase_next      = PHASE_W'(1);
                                progress_next   = '0;
                                res_valid_next  = 1'b1;
                                res_header_next = 1'b1;
                                dst_next        = header_buf_reg;
                                want_next       = BYTES_W'(HEADER_BYTES);
                                src_next        = image_offset_reg;
                                state_next      = ST_EMIT;
                            end
                            else if (phase_reg == PHASE_DONE)
                            begin
                                res_valid_next  = 1'b0;
                                res_header_next = 1'b0;
                                dst_next        = '0;
                                want_next       = '0;
                                src_next        = '0;
                                state_next      = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                size_next  = alu_res & ALIGN_MASK;
                state_next = ST_REMAIN;
            end
            ST_REMAIN:
            begin
                if (!alu_carry || (alu_res == '0))
                begin
                    // Section is empty or fully handed out: move to the next one.
                    progress_next = '0;
                    if (phase_reg == PHASE_LAST)
                    begin
                        phase_next      = PHASE_DONE;
                        res_valid_next  = 1'b0;
                        res_header_next = 1'b0;
                        dst_next        = '0;
                        want_next       = '0;
                        src_next        = '0;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        phase_next = phase_reg + PHASE_W'(1);
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    want_next  = (alu_res > CHUNK_LIMIT) ? BYTES_W'(CHUNK_BYTES)
                                                         : alu_res[BYTES_W-1:0];
                    state_next = ST_DST;
                end
            end
            ST_DST:
            begin
                dst_next   = alu_res;
                state_next = ST_SRC_BASE;
            end
            ST_SRC_BASE:
            begin
                src_next   = alu_res;
                state_next = ST_SRC_SUM;
            end
            ST_SRC_SUM:
            begin
                src_next   = alu_res;
                state_next = ST_ADVANCE;
            end
            ST_ADVANCE:
            begin
                progress_next   = alu_res;
                res_valid_next  = 1'b1;
                res_header_next = 1'b0;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                // The result waits here until the output register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next                    = 1'b1;
                    rsp_data_next.transfer_valid      = res_valid_reg;
                    rsp_data_next.header_transfer     = res_header_reg;
                    rsp_data_next.destination_address = dst_reg;
                    rsp_data_next.transfer_bytes      = want_reg;
                    rsp_data_next.source_disc_offset  = src_reg;
                    state_next                        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= '0;
            progress_reg   <= '0;
            size_reg       <= '0;
            want_reg       <= '0;
            dst_reg        <= '0;
            src_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_header_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            progress_reg   <= progress_next;
            size_reg       <= size_next;
            want_reg       <= want_next;
            dst_reg        <= dst_next;
            src_reg        <= src_next;
            res_valid_reg  <= res_valid_next;
            res_header_reg <= res_header_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_data_reg   <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef SYNTHESIS
    // The phase never runs past the finished marker.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_DONE)
        else $error("phase beyond the finished marker");

    // Progress through a section only ever moves in whole 32-byte blocks.
    a_progress_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        progress_reg[4:0] == 5'd0)
        else $error("section progress not 32-byte aligned");

    // A described transfer always moves a nonzero multiple of 32 bytes.
    a_bytes_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.transfer_valid) |->
            (rsp_data.transfer_bytes[4:0] == 5'd0) && (rsp_data.transfer_bytes != '0))
        else $error("transfer size malformed");

    // The finished answer carries all-zero fields.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.transfer_valid) |->
            !rsp_data.header_transfer && (rsp_data.transfer_bytes == '0)
            && (rsp_data.destination_address == '0)
            && (rsp_data.source_disc_offset == '0))
        else $error("finished answer has nonzero fields");

    // A header transfer is only produced for the first request after a restart.
    a_header_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && res_header_reg) |-> (phase_reg == PHASE_W'(1)))
        else $error("header transfer outside the first phase");
`endif

endmodule
